@@ design/ngfcp_pkg.sv @@
package ngfcp_pkg;

    localparam int MAX_FIELD_CHARS = 16;
    localparam int POS_W           = $clog2(MAX_FIELD_CHARS);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [3:0] COMMA_MAX = 4'd15;

    localparam logic RES_CHAR    = 1'b0;
    localparam logic RES_VERDICT = 1'b1;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] field_id_t;
    typedef logic [3:0] char_pos_t;

    typedef struct packed {
        logic      valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic      valid;
        field_id_t id;
    } field_t;

    function automatic hex_t hex_digit(byte_t c);
        hex_t h;
        h.valid = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end
        else begin
            h.valid = 1'b0;
            h.value = 4'd0;
        end
        return h;
    endfunction

    // comma fields 1, 2, 4, 9 -> time, latitude, longitude, altitude
    function automatic field_t field_of(logic [3:0] commas);
        field_t f;
        f.valid = 1'b1;
        unique case (commas)
            4'd1:    f.id = 2'd0;
            4'd2:    f.id = 2'd1;
            4'd4:    f.id = 2'd2;
            4'd9:    f.id = 2'd3;
            default:
            begin
                f.valid = 1'b0;
                f.id    = 2'd0;
            end
        endcase
        return f;
    endfunction

endpackage

@@ design/nmea_gga_field_checksum_parser_core.sv @@
// channel | handshake            | payload
// rx      | rx_valid / rx_stall  | rx_byte
// res     | res_valid / res_stall| result_kind, field_id, char_pos, char_value,
//         |                      | checksum_ok, computed_sum, received_sum
// One word per cycle sustained while res_stall stays low; a word that yields a result passes
// through the input register, then the result register.
// Reset (rst_n low, async) returns the parser to idle with empty stages.
// A stalled result holds the input register; rx_stall rises only when both are full.
module nmea_gga_field_checksum_parser_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  ngfcp_pkg::byte_t      rx_byte,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  result_kind,
    output ngfcp_pkg::field_id_t  field_id,
    output ngfcp_pkg::char_pos_t  char_pos,
    output ngfcp_pkg::byte_t      char_value,
    output logic                  checksum_ok,
    output ngfcp_pkg::byte_t      computed_sum,
    output ngfcp_pkg::byte_t      received_sum
);
    import ngfcp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_SUM
    } phase_t;

    phase_t            phase_reg, phase_next;
    byte_t             sum_reg, sum_next;
    logic [3:0]        comma_reg, comma_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    byte_t             hex_reg, hex_next;
    logic [1:0]        digits_reg, digits_next;

    logic              in_valid_reg, in_valid_next;
    byte_t             in_byte_reg, in_byte_next;

    logic              res_valid_reg, res_valid_next;
    logic              kind_reg, kind_next;
    field_id_t         fid_reg, fid_next;
    char_pos_t         cpos_reg, cpos_next;
    byte_t             cval_reg, cval_next;
    logic              ok_reg, ok_next;
    byte_t             csum_reg, csum_next;
    byte_t             rsum_reg, rsum_next;

    logic              out_free;
    logic              consume;
    logic              emit;
    hex_t              hx;
    field_t            fld;
    byte_t             c;

    assign out_free = !res_valid_reg || !res_stall;
    assign consume  = in_valid_reg && out_free;
    assign rx_stall = in_valid_reg && !out_free;

    always_comb
    begin
        c   = in_byte_reg;
        hx  = hex_digit(c);
        fld = field_of(comma_reg);

        phase_next  = phase_reg;
        sum_next    = sum_reg;
        comma_next  = comma_reg;
        pos_next    = pos_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;

        emit      = 1'b0;
        kind_next = RES_CHAR;
        fid_next  = '0;
        cpos_next = '0;
        cval_next = '0;
        ok_next   = 1'b0;
        csum_next = '0;
        rsum_next = '0;

        if (consume) begin
            if (phase_reg == PH_SUM) begin
                emit      = 1'b1;
                kind_next = RES_VERDICT;
                csum_next = sum_reg;
                rsum_next = hex_reg;
                if (hx.valid) begin
                    hex_next    = {hex_reg[3:0], hx.value};
                    digits_next = digits_reg + 2'd1;
                    rsum_next   = {hex_reg[3:0], hx.value};
                    emit        = (digits_reg == 2'd1);
                    if (emit) begin
                        phase_next = PH_IDLE;
                    end
                end
                else begin
                    phase_next = PH_IDLE;
                    if (c == CH_DOLLAR) begin
                        phase_next  = PH_BODY;
                        sum_next    = '0;
                        comma_next  = '0;
                        pos_next    = '0;
                        hex_next    = '0;
                        digits_next = '0;
                    end
                end
                ok_next = (sum_reg == rsum_next);
            end
            else if (c == CH_DOLLAR) begin
                phase_next  = PH_BODY;
                sum_next    = '0;
                comma_next  = '0;
                pos_next    = '0;
                hex_next    = '0;
                digits_next = '0;
            end
            else if (phase_reg == PH_BODY) begin
                if (c == CH_STAR) begin
                    phase_next  = PH_SUM;
                    hex_next    = '0;
                    digits_next = '0;
                end
                else begin
                    sum_next = sum_reg ^ c;
                    if (c == CH_COMMA) begin
                        if (comma_reg != COMMA_MAX) begin
                            comma_next = comma_reg + 4'd1;
                        end
                        pos_next = '0;
                    end
                    else if (fld.valid && pos_reg < POS_W'(MAX_FIELD_CHARS - 1)) begin
                        emit      = 1'b1;
                        fid_next  = fld.id;
                        cpos_next = 4'(pos_reg);
                        cval_next = c;
                        pos_next  = pos_reg + POS_W'(1);
                    end
                end
            end
        end

        if (!in_valid_reg || consume) begin
            in_valid_next = rx_valid;
            in_byte_next  = rx_byte;
        end
        else begin
            in_valid_next = in_valid_reg;
            in_byte_next  = in_byte_reg;
        end

        res_valid_next = out_free ? emit : res_valid_reg;
        if (!(out_free && emit)) begin
            kind_next = kind_reg;
            fid_next  = fid_reg;
            cpos_next = cpos_reg;
            cval_next = cval_reg;
            ok_next   = ok_reg;
            csum_next = csum_reg;
            rsum_next = rsum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            sum_reg       <= '0;
            comma_reg     <= '0;
            pos_reg       <= '0;
            hex_reg       <= '0;
            digits_reg    <= '0;
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= RES_CHAR;
            fid_reg       <= '0;
            cpos_reg      <= '0;
            cval_reg      <= '0;
            ok_reg        <= 1'b0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
        end
        else begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            comma_reg     <= comma_next;
            pos_reg       <= pos_next;
            hex_reg       <= hex_next;
            digits_reg    <= digits_next;
            in_valid_reg  <= in_valid_next;
            in_byte_reg   <= in_byte_next;
            res_valid_reg <= res_valid_next;
            kind_reg      <= kind_next;
            fid_reg       <= fid_next;
            cpos_reg      <= cpos_next;
            cval_reg      <= cval_next;
            ok_reg        <= ok_next;
            csum_reg      <= csum_next;
            rsum_reg      <= rsum_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_kind  = kind_reg;
    assign field_id     = fid_reg;
    assign char_pos     = cpos_reg;
    assign char_value   = cval_reg;
    assign checksum_ok  = ok_reg;
    assign computed_sum = csum_reg;
    assign received_sum = rsum_reg;

endmodule

@@ dv/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ngfcp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 430;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_BODY, SCAN_SUM} scan_e;

    typedef struct packed {
        logic      kind;
        field_id_t fid;
        char_pos_t pos;
        byte_t     value;
        logic      ok;
        byte_t     csum;
        byte_t     rsum;
    } nmea_res_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_stall;
    byte_t     rx_byte = 8'h00;
    logic      res_valid;
    logic      res_stall = 1'b0;
    logic      result_kind;
    field_id_t field_id;
    char_pos_t char_pos;
    byte_t     char_value;
    logic      checksum_ok;
    byte_t     computed_sum;
    byte_t     received_sum;

    byte_t     sentence_bytes[$];
    nmea_res_t expected_out[$];
    int        mismatches = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    logic      rx_took = 1'b0;
    int        quiet_cycles = 0;

    // parser state as the block should hold it
    scan_e      scan = SCAN_IDLE;
    byte_t      sum_acc = 8'h00;
    logic [3:0] commas = 4'd0;
    int         fpos = 0;
    byte_t      hex_acc = 8'h00;
    int         hex_cnt = 0;

    nmea_gga_field_checksum_parser_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .result_kind  (result_kind),
        .field_id     (field_id),
        .char_pos     (char_pos),
        .char_value   (char_value),
        .checksum_ok  (checksum_ok),
        .computed_sum (computed_sum),
        .received_sum (received_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int hex_nibble(byte_t c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    // comma count -> reported field, -1 when the field is not extracted
    function automatic int field_slot(logic [3:0] n);
        unique case (n)
            4'd1:    return 0;
            4'd2:    return 1;
            4'd4:    return 2;
            4'd9:    return 3;
            default: return -1;
        endcase
    endfunction

    function automatic void open_sentence();
        scan    = SCAN_BODY;
        sum_acc = 8'h00;
        commas  = 4'd0;
        fpos    = 0;
        hex_acc = 8'h00;
        hex_cnt = 0;
    endfunction

    function automatic void parse_byte(byte_t c);
        int        nib;
        int        slot;
        nmea_res_t r;
        nib = hex_nibble(c);
        r = '0;
        if (scan == SCAN_SUM)
        begin
            if (nib >= 0)
            begin
                hex_acc = {hex_acc[3:0], 4'(nib)};
                hex_cnt++;
                if (hex_cnt < 2)
                begin
                    return;
                end
            end
            r.kind = RES_VERDICT;
            r.ok   = (sum_acc == hex_acc);
            r.csum = sum_acc;
            r.rsum = hex_acc;
            expected_out.push_back(r);
            scan = SCAN_IDLE;
            if (c == CH_DOLLAR)
            begin
                open_sentence();
            end
            return;
        end
        if (c == CH_DOLLAR)
        begin
            open_sentence();
            return;
        end
        if (scan != SCAN_BODY)
        begin
            return;
        end
        if (c == CH_STAR)
        begin
            scan    = SCAN_SUM;
            hex_acc = 8'h00;
            hex_cnt = 0;
            return;
        end
        sum_acc ^= c;
        if (c == CH_COMMA)
        begin
            if (commas < COMMA_MAX)
            begin
                commas++;
            end
            fpos = 0;
            return;
        end
        slot = field_slot(commas);
        if (slot < 0 || fpos >= MAX_FIELD_CHARS - 1)
        begin
            return;
        end
        r.kind  = RES_CHAR;
        r.fid   = field_id_t'(slot);
        r.pos   = char_pos_t'(fpos);
        r.value = c;
        expected_out.push_back(r);
        fpos++;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            sentence_bytes.push_back(byte_t'(s[i]));
        end
    endfunction

    function automatic byte_t field_char();
        string pool;
        byte_t c;
        pool = "0123456789.NSEWM-";
        if ($urandom_range(7) == 0)
        begin
            do
            begin
                c = byte_t'($urandom);
            end
            while (c == CH_DOLLAR || c == CH_STAR);
            return c;
        end
        return byte_t'(pool[$urandom_range(pool.len() - 1)]);
    endfunction

    function automatic byte_t hex_char(logic [3:0] n);
        if (n < 4'd10)
        begin
            return byte_t'("0") + byte_t'(n);
        end
        if ($urandom_range(1) == 0)
        begin
            return byte_t'("A") + byte_t'(n) - 8'd10;
        end
        return byte_t'("a") + byte_t'(n) - 8'd10;
    endfunction

    function automatic byte_t non_hex();
        byte_t c;
        do
        begin
            c = byte_t'($urandom);
        end
        while (hex_nibble(c) >= 0);
        return c;
    endfunction

    // one sentence with random content; some are cut short or carry a bad checksum
    function automatic void push_sentence();
        int    nfields;
        int    flen;
        int    style;
        byte_t c;
        byte_t sum;
        sum = 8'h00;
        sentence_bytes.push_back(CH_DOLLAR);
        nfields = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(14);
        for (int f = 0; f <= nfields; f++)
        begin
            if (f != 0)
            begin
                sentence_bytes.push_back(CH_COMMA);
                sum ^= CH_COMMA;
            end
            flen = ($urandom_range(11) == 0) ? $urandom_range(24) : $urandom_range(7);
            for (int k = 0; k < flen; k++)
            begin
                c = field_char();
                sentence_bytes.push_back(c);
                sum ^= c;
            end
        end
        style = $urandom_range(19);
        if (style == 0)
        begin
            return;
        end
        sentence_bytes.push_back(CH_STAR);
        unique case (style)
            1: ;
            2:
            begin
                sentence_bytes.push_back(hex_char(4'($urandom)));
                sentence_bytes.push_back(non_hex());
            end
            3: sentence_bytes.push_back(non_hex());
            4, 5:
            begin
                sum ^= byte_t'($urandom_range(255, 1));
                sentence_bytes.push_back(hex_char(sum[7:4]));
                sentence_bytes.push_back(hex_char(sum[3:0]));
            end
            default:
            begin
                sentence_bytes.push_back(hex_char(sum[7:4]));
                sentence_bytes.push_back(hex_char(sum[3:0]));
            end
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!rx_valid || rx_took)
            begin
                if (sentence_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= sentence_bytes.pop_front();
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        nmea_res_t want;
        if (rst_n)
        begin
            rx_took <= rx_valid && !rx_stall;
            if (res_valid && !res_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: kind %0d", result_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    check_field("result_kind", want.kind, result_kind);
                    check_field("field_id", want.fid, field_id);
                    check_field("char_pos", want.pos, char_pos);
                    check_field("char_value", want.value, char_value);
                    check_field("checksum_ok", want.ok, checksum_ok);
                    check_field("computed_sum", want.csum, computed_sum);
                    check_field("received_sum", want.rsum, received_sum);
                end
            end
            if (rx_valid && !rx_stall)
            begin
                parse_byte(rx_byte);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("nmea_gga_field_checksum_parser_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_sched[4];
        int stall_sched[4];
        idle_sched  = '{0, 78, 0, 36};
        stall_sched = '{0, 0, 78, 36};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle bytes ignored, restart in the body, dollar and non-hex ending a checksum
        sentence_bytes.push_back(8'h00);
        sentence_bytes.push_back(8'hFF);
        push_str("$,ab$,,c*0$,z");
        sentence_bytes.push_back(8'hFF);
        sentence_bytes.push_back(8'h00);
        push_str("*Fa$*G");

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_sched[p];
            stall_pct = stall_sched[p];
            while (sentence_bytes.size() < PHASE_WORDS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    repeat ($urandom_range(6, 1)) sentence_bytes.push_back(byte_t'($urandom));
                end
                else
                begin
                    push_sentence();
                end
            end
            while (sentence_bytes.size() != 0 || rx_valid || expected_out.size() != 0)
            begin
                @(negedge clk);
            end
        end

        repeat (4) @(posedge clk);
        if (expected_out.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_out.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("nmea_gga_field_checksum_parser_core: match");
        end
        else
        begin
            $display("nmea_gga_field_checksum_parser_core: mismatch");
        end
        $finish;
    end

endmodule
